[hw/rtl/hmad_pkg.sv]
// ----------------------------------------------------------------------------
// hmad_pkg
// Shared types and constants of the Haar / MAD rate anomaly detector.
// ----------------------------------------------------------------------------
package hmad_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int WINDOW_LEN_DEF   = 16;
  localparam int BASELINE_LEN_DEF = 100;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 16;
  localparam int SCORE_THR_W      = 15;

  // 1/sqrt2 in Q0.32 and 1.4826 in Q16.
  localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
  localparam logic [16:0] MAD_SCALE_Q16 = 17'd97164;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_THR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 8'd1;

  localparam logic [15:0] AVG_THR_RST   = 16'd7680;
  localparam logic [14:0] SCORE_THR_RST = 15'd2048;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rate_sample;
    logic                   start_record;
  } in_word_t;

  typedef struct packed {
    logic [15:0]            sample_number;
    logic [SAMPLE_BITS-1:0] window_mean;
    logic [SAMPLE_BITS-1:0] detail_value;
    logic signed [15:0]     robust_score;
    logic                   score_valid;
    logic                   mean_alert;
    logic                   score_alert;
  } out_word_t;

  // Control of the sorting chain.
  typedef struct packed {
    logic shift;
    logic load_dev;
    logic sort;
    logic phase;
  } chain_ctrl_t;

endpackage

[hw/rtl/haar_mad_rate_anomaly_detector.sv]
// ----------------------------------------------------------------------------
// haar_mad_rate_anomaly_detector
// Rolling mean, Haar detail and robust z-score of packet-rate samples.
// ----------------------------------------------------------------------------
// One word in gives one word out. With the output free, each word passes
// through window update, detail, divider start, a wait on the score divider
// (25 quotient bits, the longer of the two dividers, which run side by side),
// the output load and a return to idle before the next word is taken. The
// output register lets the next word in while a result waits. The sample that
// completes the baseline (sample BASELINE_LEN-1 of a record) also runs two
// odd-even transposition sorts over the chain of BASELINE_LEN-1 cells, one
// phase a cycle, which lengthens that sample alone. Register writes are taken
// only while the block is idle.
module haar_mad_rate_anomaly_detector
  import hmad_pkg::*;
#(
  parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
  parameter int BASELINE_LEN = BASELINE_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DC      = BASELINE_LEN - 1;
  localparam int HEAD_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W   = SAMPLE_BITS + FILL_W;
  localparam int MNUM_W  = SUM_W + 1;
  localparam int SNUM_W  = SAMPLE_BITS + 9;
  localparam int SCNT_W  = $clog2(DC + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_DET, S_SORT1, S_MED, S_SORT2, S_MAD, S_SIG, S_SCORE,
    S_DIV, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0]            avg_thr_q;
  logic [14:0]            score_thr_q;
  logic [SAMPLE_BITS-1:0] ring_q [WINDOW_LEN];
  logic [HEAD_W-1:0]      head_q;
  logic [SUM_W-1:0]       sum_q;
  logic [FILL_W-1:0]      fill_q;
  logic [SAMPLE_BITS-1:0] prev_q;
  logic [15:0]            count_q;
  logic [SAMPLE_BITS-1:0] median_q;
  logic [SAMPLE_BITS-1:0] sigma_q;
  logic                   cal_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [15:0]            number_q;
  logic [47:0]            prod_q;
  logic [SAMPLE_BITS-1:0] detail_q;
  logic [33:0]            sprod_q;
  logic [SCNT_W-1:0]      scnt_q;
  logic                   neg_q;
  logic                   out_valid_q;
  out_word_t              out_q;
  logic                   out_load;

  // Chain signals.
  chain_ctrl_t            ctrl;
  logic [SAMPLE_BITS-1:0] mid_lo, mid_hi, med_w;
  logic [SAMPLE_BITS:0]   mid_sum;

  // Window and detail helpers.
  logic [SAMPLE_BITS-1:0] evict, diff;
  logic [SAMPLE_BITS-1:0] detail_w;
  logic                   store_en;

  // Dividers.
  logic                   div_start;
  logic [MNUM_W-1:0]      mnum, mquot;
  logic [SNUM_W-1:0]      snum, squot;
  logic                   mbusy, sbusy;
  logic [SAMPLE_BITS-1:0] mag;

  // Results.
  logic [SAMPLE_BITS-1:0] mad_w;
  logic [17:0]            sig_w;
  logic signed [15:0]     score_w;
  logic [SAMPLE_BITS-1:0] mean_w;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign evict    = (fill_q == FILL_W'(WINDOW_LEN)) ? ring_q[head_q] : '0;
  assign diff     = (x_q >= prev_q) ? x_q - prev_q : prev_q - x_q;
  assign detail_w = prod_q[47:32] + {15'd0, prod_q[31]};
  assign store_en = !cal_q && number_q >= 16'd1 && number_q <= 16'(DC);

  assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi} + 1'b1;
  assign med_w   = mid_sum[SAMPLE_BITS:1];
  assign mad_w   = (med_w == '0) ? SAMPLE_BITS'(1) : med_w;
  assign sig_w   = sprod_q[33:16];

  always_comb begin
    ctrl          = '0;
    ctrl.shift    = (state_q == S_DET) && store_en;
    ctrl.sort     = (state_q == S_SORT1) || (state_q == S_SORT2);
    ctrl.phase    = scnt_q[0];
    ctrl.load_dev = (state_q == S_MED);
  end

  hmad_sort_chain #(.N(DC)) u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .shift_in_i (detail_w),
    .median_i   (med_w),
    .mid_lo_o   (mid_lo),
    .mid_hi_o   (mid_hi)
  );

  assign div_start = (state_q == S_SCORE);
  assign mag  = (detail_q < median_q) ? median_q - detail_q : detail_q - median_q;
  assign mnum = MNUM_W'(sum_q) + MNUM_W'(fill_q >> 1);
  assign snum = {1'b0, mag, 8'd0} + SNUM_W'(sigma_q >> 1);

  hmad_divider #(.NUM_W(MNUM_W), .DEN_W(FILL_W)) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mnum),
    .den_i   (fill_q),
    .busy_o  (mbusy),
    .quot_o  (mquot)
  );

  hmad_divider #(.NUM_W(SNUM_W), .DEN_W(SAMPLE_BITS)) u_score_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (snum),
    .den_i   (sigma_q),
    .busy_o  (sbusy),
    .quot_o  (squot)
  );

  assign mean_w = mquot[SAMPLE_BITS-1:0];

  always_comb begin
    score_w = '0;
    if (cal_q) begin
      if (neg_q) begin
        score_w = (squot > SNUM_W'(32768)) ? 16'sh8000 : 16'(-squot);
      end else begin
        score_w = (squot > SNUM_W'(32767)) ? 16'sh7FFF : 16'(squot);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WIN) ring_q[head_q] <= x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      avg_thr_q   <= AVG_THR_RST;
      score_thr_q <= SCORE_THR_RST;
      head_q      <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
      prev_q      <= '0;
      count_q     <= '0;
      median_q    <= '0;
      sigma_q     <= SAMPLE_BITS'(1);
      cal_q       <= 1'b0;
      x_q         <= '0;
      number_q    <= '0;
      prod_q      <= '0;
      detail_q    <= '0;
      sprod_q     <= '0;
      neg_q       <= 1'b0;
      scnt_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_AVG_THR:   avg_thr_q   <= cfg_data_i[15:0];
          CFG_SCORE_THR: score_thr_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x_q <= in_word_i.rate_sample;
            if (in_word_i.start_record) begin
              head_q   <= '0;
              sum_q    <= '0;
              fill_q   <= '0;
              prev_q   <= '0;
              count_q  <= '0;
              median_q <= '0;
              sigma_q  <= SAMPLE_BITS'(1);
              cal_q    <= 1'b0;
            end
            state_q <= S_WIN;
          end
        end
        S_WIN: begin
          sum_q    <= sum_q - SUM_W'(evict) + SUM_W'(x_q);
          head_q   <= (head_q == HEAD_W'(WINDOW_LEN - 1)) ? '0 : head_q + 1'b1;
          if (fill_q != FILL_W'(WINDOW_LEN)) fill_q <= fill_q + 1'b1;
          number_q <= count_q;
          prod_q   <= (count_q != '0) ? 48'(diff) * 48'(INV_SQRT2_Q32) : '0;
          prev_q   <= x_q;
          if (count_q != 16'hFFFF) count_q <= count_q + 1'b1;
          state_q  <= S_DET;
        end
        S_DET: begin
          detail_q <= detail_w;
          scnt_q   <= '0;
          if (store_en && number_q == 16'(DC)) begin
            state_q <= S_SORT1;
          end else begin
            state_q <= S_SCORE;
          end
        end
        S_SORT1: begin
          scnt_q <= scnt_q + 1'b1;
          if (scnt_q == SCNT_W'(DC - 1)) state_q <= S_MED;
        end
        S_MED: begin
          // The chain loads |d - median| in this same cycle.
          median_q <= med_w;
          scnt_q   <= '0;
          state_q  <= S_SORT2;
        end
        S_SORT2: begin
          scnt_q <= scnt_q + 1'b1;
          if (scnt_q == SCNT_W'(DC - 1)) state_q <= S_MAD;
        end
        S_MAD: begin
          sprod_q <= 34'(mad_w) * 34'(MAD_SCALE_Q16) + 34'd32768;
          state_q <= S_SIG;
        end
        S_SIG: begin
          sigma_q <= (sig_w[17:16] != 2'b00) ? '1 : sig_w[15:0];
          cal_q   <= 1'b1;
          state_q <= S_SCORE;
        end
        S_SCORE: begin
          neg_q   <= detail_q < median_q;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!mbusy && !sbusy) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_q.sample_number <= number_q;
            out_q.window_mean   <= mean_w;
            out_q.detail_value  <= detail_q;
            out_q.robust_score  <= score_w;
            out_q.score_valid   <= cal_q;
            out_q.mean_alert    <= mean_w > avg_thr_q;
            out_q.score_alert   <= cal_q && (score_w > $signed({1'b0, score_thr_q}));
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/hmad_sort_cell.sv]
// ----------------------------------------------------------------------------
// hmad_sort_cell
// One cell of the baseline chain: shift, deviation load and odd-even
// compare-exchange with a neighbor.
// ----------------------------------------------------------------------------
module hmad_sort_cell
  import hmad_pkg::*;
#(
  parameter int IDX = 0,
  parameter int N   = 99
) (
  input  logic                   clk_i,
  input  chain_ctrl_t            ctrl_i,
  input  logic [SAMPLE_BITS-1:0] left_i,
  input  logic [SAMPLE_BITS-1:0] right_i,
  input  logic [SAMPLE_BITS-1:0] median_i,
  output logic [SAMPLE_BITS-1:0] value_o
);

  localparam logic MY_PAR = IDX[0];

  logic [SAMPLE_BITS-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = left_i;
    end else if (ctrl_i.load_dev) begin
      value_d = (value_q >= median_i) ? value_q - median_i : median_i - value_q;
    end else if (ctrl_i.sort) begin
      // Pair (i, i+1) is active when i has the parity of the phase.
      if (MY_PAR == ctrl_i.phase && IDX + 1 < N) begin
        if (right_i < value_q) value_d = right_i;
      end else if (MY_PAR != ctrl_i.phase && IDX > 0) begin
        if (left_i > value_q) value_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[hw/rtl/hmad_sort_chain.sv]
// ----------------------------------------------------------------------------
// hmad_sort_chain
// Row of cells that holds the baseline details and sorts them in place.
// ----------------------------------------------------------------------------
module hmad_sort_chain
  import hmad_pkg::*;
#(
  parameter int N = 99
) (
  input  logic                   clk_i,
  input  chain_ctrl_t            ctrl_i,
  input  logic [SAMPLE_BITS-1:0] shift_in_i,
  input  logic [SAMPLE_BITS-1:0] median_i,
  output logic [SAMPLE_BITS-1:0] mid_lo_o,
  output logic [SAMPLE_BITS-1:0] mid_hi_o
);

  localparam int MID_HI = N / 2;
  localparam int MID_LO = (N % 2 == 0) ? N / 2 - 1 : N / 2;

  logic [SAMPLE_BITS-1:0] val [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = shift_in_i;
    end else begin : g_mid
      assign left_w = val[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_w = val[g];
    end else begin : g_inner
      assign right_w = val[g+1];
    end
    hmad_sort_cell #(.IDX(g), .N(N)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .left_i   (left_w),
      .right_i  (right_w),
      .median_i (median_i),
      .value_o  (val[g])
    );
  end

  assign mid_lo_o = val[MID_LO];
  assign mid_hi_o = val[MID_HI];

endmodule

[hw/rtl/hmad_divider.sv]
// ----------------------------------------------------------------------------
// hmad_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hmad_divider
  import hmad_pkg::*;
#(
  parameter int NUM_W = 21,
  parameter int DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Haar / MAD rate anomaly detector. A scoreboard
// class predicts every output word from the accepted input words and the
// threshold registers, and compares each output word as a whole. The
// stimulus covers directed corners, then whole records, constant and random,
// that run through calibration, mostly under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import hmad_pkg::*;

  localparam int DETAILS = BASELINE_LEN_DEF - 1;
  localparam int WIN     = WINDOW_LEN_DEF;

  // Register indexes that select no register.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hFF;

  class rate_scoreboard;
    logic [15:0] avg_thr;
    logic [14:0] score_thr;
    logic [15:0] ring [WIN];
    int unsigned head, fill, count;
    longint unsigned sum;
    logic [15:0] prev_sample, median, sigma;
    logic [15:0] details [DETAILS];
    bit calibrated;
    out_word_t pending [$];
    int unsigned mismatches, checked, scored_words;

    function void clear_record();
      foreach (ring[i]) ring[i] = '0;
      head = 0;
      fill = 0;
      count = 0;
      sum = 0;
      prev_sample = '0;
      median = '0;
      sigma = 16'd1;
      calibrated = 0;
    endfunction

    function void init();
      avg_thr = AVG_THR_RST;
      score_thr = SCORE_THR_RST;
      mismatches = 0;
      checked = 0;
      scored_words = 0;
      clear_record();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_AVG_THR) avg_thr = data;
      else if (idx == CFG_SCORE_THR) score_thr = data[14:0];
    endfunction

    function longint unsigned median_of(longint unsigned vals [DETAILS]);
      longint unsigned q [$];
      foreach (vals[i]) q.push_back(vals[i]);
      q.sort();
      if (DETAILS % 2 == 0) return (q[DETAILS/2-1] + q[DETAILS/2] + 1) >> 1;
      return q[DETAILS/2];
    endfunction

    function void calibrate();
      longint unsigned vals [DETAILS];
      longint unsigned med, mad, sig;
      foreach (details[i]) vals[i] = details[i];
      med = median_of(vals);
      foreach (details[i])
        vals[i] = (details[i] >= med) ? details[i] - med : med - details[i];
      mad = median_of(vals);
      if (mad < 1) mad = 1;
      sig = (mad * 97164 + 32768) >> 16;
      if (sig < 1) sig = 1;
      if (sig > 65535) sig = 65535;
      median = 16'(med);
      sigma = 16'(sig);
      calibrated = 1;
    endfunction

    function void note_input(in_word_t w);
      out_word_t e;
      longint unsigned mean, diff, detail, mag, quo;
      longint score;
      bit neg;
      if (w.start_record) clear_record();
      e = '0;
      e.sample_number = 16'(count);
      sum = sum - ring[head] + w.rate_sample;
      ring[head] = w.rate_sample;
      head = (head + 1) % WIN;
      if (fill < WIN) fill++;
      mean = (sum + fill / 2) / fill;
      detail = 0;
      if (count > 0) begin
        diff = (w.rate_sample >= prev_sample) ? w.rate_sample - prev_sample
                                              : prev_sample - w.rate_sample;
        detail = (diff * 64'd3037000500 + 64'h8000_0000) >> 32;
      end
      prev_sample = w.rate_sample;
      if (!calibrated && count >= 1 && count <= DETAILS) begin
        details[count-1] = 16'(detail);
        if (count == DETAILS) calibrate();
      end
      score = 0;
      if (calibrated) begin
        neg = detail < median;
        mag = neg ? median - detail : detail - median;
        quo = ((mag << 8) + sigma / 2) / sigma;
        if (neg) score = (quo > 32768) ? -32768 : -longint'(quo);
        else score = (quo > 32767) ? 32767 : longint'(quo);
        scored_words++;
      end
      if (count < 65535) count++;
      e.window_mean = 16'(mean);
      e.detail_value = 16'(detail);
      e.robust_score = score[15:0];
      e.score_valid = calibrated;
      e.mean_alert = mean > avg_thr;
      e.score_alert = calibrated && (score > longint'(score_thr));
      pending.push_back(e);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output word %p", got);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: output word %0d mismatch", checked);
          $display("  expected %p", e);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_word;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rate_scoreboard sb = new();
  bit no_idle = 0;
  int unsigned words_sent = 0;

  haar_mad_rate_anomaly_detector u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Monitors see pre-edge values, since every driver uses nonblocking writes.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_word);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  initial begin
    int unsigned n;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      n = gap_len();
      out_stall <= (n != 0);
      repeat (n) @(posedge clk);
      if (n != 0) out_stall <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_word(logic [15:0] sample, logic start);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_word <= '{rate_sample: sample, start_record: start};
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // One record: a start word, then samples from a base up to base plus a given
  // spread, long enough to calibrate, with occasional spikes afterwards.
  task automatic send_record(int unsigned len, int unsigned base, int unsigned spread);
    int unsigned v;
    for (int i = 0; i < len; i++) begin
      if (spread == 0) v = base;
      else v = base + $urandom_range(0, spread);
      if (i > 100 && $urandom_range(0, 15) == 0) v = $urandom_range(0, 65535);
      if (v > 65535) v = 65535;
      send_word(v[15:0], i == 0);
    end
  endtask

  initial begin
    int unsigned mode;
    sb.init();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed corners with reset thresholds; the first word has no start flag.
    send_word(16'd0, 0);
    send_word(16'hFFFF, 0);
    send_word(16'd0, 0);
    send_word(16'hFFFF, 0);
    send_word(16'h1E00, 0);
    send_word(16'h1E01, 0);
    send_word(16'h5555, 1);
    send_word(16'hAAAA, 0);
    send_word(16'h0001, 0);
    send_word(16'h8000, 0);
    for (int i = 0; i < 16; i++) send_word(16'hFFFF, 0);
    drain();

    // Constant record: zero deviation floors at one LSB.
    write_reg(CFG_AVG_THR, 16'd0);
    write_reg(CFG_SCORE_THR, 16'd0);
    write_reg(CFG_IDX_UNUSED, 16'h1234);
    write_reg(CFG_IDX_TOP, 16'hFFFF);
    send_record(110, 16'h0100, 0);
    send_word(16'hFFFF, 0);
    send_word(16'h0000, 0);
    drain();

    write_reg(CFG_AVG_THR, 16'hFFFF);
    write_reg(CFG_SCORE_THR, 16'hFFFF);
    no_idle = 1;
    send_record(130, 16'd0, 65535);
    no_idle = 0;
    drain();

    for (int r = 0; r < 3; r++) begin
      write_reg(CFG_AVG_THR, 16'($urandom_range(0, 65535)));
      write_reg(CFG_SCORE_THR, 16'($urandom_range(0, 65535)));
      mode = $urandom_range(0, 2);
      case (mode)
        0: begin
          send_record($urandom_range(105, 140), $urandom_range(0, 65000), 30);
        end
        1: begin
          send_record($urandom_range(105, 140), $urandom_range(0, 40000), 2000);
        end
        default: begin
          send_record($urandom_range(105, 140), 0, 65535);
        end
      endcase
      // Noise: broken records restarted before calibration.
      for (int i = 0; i < 8; i++)
        send_word(16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
      drain();
    end

    write_reg(CFG_AVG_THR, 16'h8000);
    write_reg(CFG_SCORE_THR, 16'd100);
    send_record(120, 16'h3000, 5);
    drain();

    $display("Covered %0d input words and %0d output words, %0d of them scored.",
             words_sent, sb.checked, sb.scored_words);
    $display("Thresholds swept through both extremes across several records.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d output words outstanding.", sb.pending.size());
    $display("tb_top failed");
    $finish;
  end

endmodule

[haar_mad_rate_anomaly_detector.f]
hw/rtl/hmad_pkg.sv
hw/rtl/hmad_sort_cell.sv
hw/rtl/hmad_sort_chain.sv
hw/rtl/hmad_divider.sv
hw/rtl/haar_mad_rate_anomaly_detector.sv
tb/tb_top.sv
